>>> hw/rtl/alarm_line_key_value_parser_assert.svh
// Assertion macros for the alarm line parser checkers.
// Expects aclk and aresetn in scope where a macro is used.
`ifndef ALARM_LINE_KEY_VALUE_PARSER_ASSERT_SVH
`define ALARM_LINE_KEY_VALUE_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define ALKV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define ALKV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/alkv_pkg.sv
// Shared types, constants and character helpers for the alarm line parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package alkv_pkg;

    // Sizing
    localparam int NAME_MAX      = 32;
    localparam int PREFIX_LENGTH = 13;
    localparam int DET_DEPTH     = NAME_MAX - 1;
    localparam int DET_CNT_W     = $clog2(NAME_MAX);
    localparam int PFX_POS_W     = 5;

    // Port widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;
    localparam int TUSER_W   = 2;

    // Value limits
    localparam logic [6:0] CONF_MAX = 7'd100;
    localparam logic [1:0] SRC_INVALID = 2'd3;

    // Characters
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_LX  = 8'h78;
    localparam logic [7:0] CH_UX  = 8'h58;

    // Line prefix, padded with zeros to the full position range
    localparam logic [7:0] PREFIX_TABLE [32] = '{
        8'h42, 8'h41, 8'h53, 8'h41, 8'h4E, 8'h4F, 8'h53, 8'h2D,
        8'h41, 8'h4C, 8'h41, 8'h52, 8'h4D, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Known keys; fam is padded to four entries
    localparam logic [7:0] KEY_DET_TEXT [8] = '{
        8'h64, 8'h65, 8'h74, 8'h65, 8'h63, 8'h74, 8'h6F, 8'h72
    };
    localparam logic [7:0] KEY_CONF_TEXT [4] = '{8'h63, 8'h6F, 8'h6E, 8'h66};
    localparam logic [7:0] KEY_FAM_TEXT  [4] = '{8'h66, 8'h61, 8'h6D, 8'h00};
    localparam logic [3:0] KEY_DET_LEN  = 4'd8;
    localparam logic [3:0] KEY_CONF_LEN = 4'd4;
    localparam logic [3:0] KEY_FAM_LEN  = 4'd3;

    // Key candidate bit positions
    localparam int KB_DET  = 0;
    localparam int KB_CONF = 1;
    localparam int KB_FAM  = 2;

    typedef enum logic [8:0] {
        PH_LEAD   = 9'b000000001,
        PH_PREFIX = 9'b000000010,
        PH_AFTER  = 9'b000000100,
        PH_GAP    = 9'b000001000,
        PH_KEY    = 9'b000010000,
        PH_VALUE  = 9'b000100000,
        PH_SKIP   = 9'b001000000,
        PH_FAIL   = 9'b010000000,
        PH_ENDED  = 9'b100000000
    } phase_t;

    // Verdict of one finished line, handed from parser to emitter
    typedef struct packed {
        logic                 valid;
        logic [1:0]           src;
        logic [6:0]           conf;
        logic [7:0]           fam;
        logic [DET_CNT_W-1:0] cnt;
    } line_sum_t;

    function automatic logic is_ws(input logic [7:0] ch);
        return (ch == CH_SP) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/alarm_line_key_value_parser.sv
// Flow: a word is registered at the edge it is taken; an end-of-line verdict is
//   then loaded into the output register once that register is free.
// Throughput: one character word per cycle; the parser stalls while a run drains. An
//   end-of-line word with N stored name bytes gives max(N,1) result words, one per
//   cycle unless the output stalls, through the single read port of the name store.
// Reset: synchronous on aresetn low; clears the line state and both valids.
// Top level of the alarm line key=value parser; depends on alkv_pkg,
// alkv_parse and alkv_emit.
`default_nettype none

module alarm_line_key_value_parser
    import alkv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] char_byte
    input  logic                 s_tlast,   // end_of_line
    input  logic [TUSER_W-1:0]   s_tuser,   // [1:0] source
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] valid_res, [7:1] confidence,
                                            // [15:8] families, [20:16] detector_length,
                                            // [28:21] name_byte, [33:29] name_index,
                                            // [39:34] zero
    output logic                 m_tlast,   // last
    output logic [TUSER_W-1:0]   m_tuser    // [1:0] source_echo
);

    // The parser updates its line state from the input register every cycle
    // the emitter is not draining a run. The name store lives in the parser;
    // the emitter reads it one byte per result word and keeps the parser
    // stalled until the last byte has left the store.
    logic                 line_done;
    line_sum_t            line_sum;
    logic                 emit_busy;
    logic [DET_CNT_W-1:0] rd_idx;
    logic [7:0]           rd_byte;

    alkv_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .emit_busy (emit_busy),
        .line_done (line_done),
        .line_sum  (line_sum),
        .rd_idx    (rd_idx),
        .rd_byte   (rd_byte)
    );

    // Result words wait in the output register; the parser keeps taking
    // characters while a finished single-word verdict waits there.
    alkv_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .line_done (line_done),
        .line_sum  (line_sum),
        .emit_busy (emit_busy),
        .rd_idx    (rd_idx),
        .rd_byte   (rd_byte),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

>>> hw/rtl/alkv_parse.sv
// Input register, per-character line parser and detector name store.
// Depends on alkv_pkg.
`default_nettype none

module alkv_parse
    import alkv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic [TUSER_W-1:0]   s_tuser,
    input  logic                 emit_busy,
    output logic                 line_done,
    output line_sum_t            line_sum,
    input  logic [DET_CNT_W-1:0] rd_idx,
    output logic [7:0]           rd_byte
);

    // input register
    logic               in_valid_reg;
    logic [7:0]         in_char_reg;
    logic               in_eol_reg;
    logic [TUSER_W-1:0] in_src_reg;

    // parse state
    phase_t                phase_reg, phase_next;
    logic [PFX_POS_W-1:0]  pfx_pos_reg, pfx_pos_next;
    logic [3:0]            klen_reg, klen_next;
    logic [2:0]            kflags_reg, kflags_next;
    logic [31:0]           acc_reg, acc_next;
    logic                  vhex_reg, vhex_next;
    logic                  vxpend_reg, vxpend_next;
    logic                  vany_reg, vany_next;
    logic                  verr_reg, verr_next;
    logic [1:0]            vlen_reg, vlen_next;
    logic [DET_CNT_W-1:0]  det_count_reg, det_count_next;
    logic [6:0]            conf_reg, conf_next;
    logic [7:0]            fam_reg, fam_next;
    logic                  have_det_reg, have_det_next;
    logic [7:0]            det_store_reg [DET_DEPTH];

    logic                  consume, step;
    logic [7:0]            ch;
    logic                  ws, ch_nul;
    logic [PFX_POS_W-1:0]  pfx_pos_cur;
    logic [PFX_POS_W:0]    pfx_pos_inc;
    logic                  pfx_hit;
    logic [3:0]            klen_base;
    logic [2:0]            kflags_base;
    logic                  det_hit, conf_hit, fam_hit;
    logic [2:0]            kflags_key;
    logic [3:0]            klen_inc;
    logic [2:0]            kflags_val;
    logic [DET_CNT_W-1:0]  det_idx;
    logic                  det_room, det_we;
    logic                  is_num, x_start, hex_eff;
    logic [31:0]           acc_eff;
    logic                  dig_ok;
    logic [3:0]            dig_val;
    logic [35:0]           acc_wide, prod, sum;
    logic                  ovf;
    logic                  fin_ok;
    logic [6:0]            fin_conf, conf_sat;
    logic [7:0]            fin_fam;
    logic                  src_ok, pre_ok, line_ok;

    assign consume   = in_valid_reg && !emit_busy;
    assign s_tready  = !in_valid_reg || !emit_busy;
    assign step      = consume && !in_eol_reg;
    assign line_done = consume && in_eol_reg;
    assign ch        = in_char_reg;
    assign ws        = is_ws(ch);
    assign ch_nul    = (ch == CH_NUL);

    // prefix compare; leading whitespace phase starts at position zero
    assign pfx_pos_cur = (phase_reg == PH_LEAD) ? '0 : pfx_pos_reg;
    assign pfx_pos_inc = {1'b0, pfx_pos_cur} + 1'b1;
    assign pfx_hit     = !ch_nul && (ch == PREFIX_TABLE[pfx_pos_cur]);

    // key candidate tracking; a key begins fresh out of the gap phase
    assign klen_base   = (phase_reg == PH_GAP) ? 4'd0 : klen_reg;
    assign kflags_base = (phase_reg == PH_GAP) ? 3'b111 : kflags_reg;
    assign det_hit  = (klen_base < KEY_DET_LEN) && (ch == KEY_DET_TEXT[klen_base[2:0]]);
    assign conf_hit = (klen_base < KEY_CONF_LEN) && (ch == KEY_CONF_TEXT[klen_base[1:0]]);
    assign fam_hit  = (klen_base < KEY_FAM_LEN) && (ch == KEY_FAM_TEXT[klen_base[1:0]]);
    assign kflags_key = kflags_base & {fam_hit, conf_hit, det_hit};
    assign klen_inc   = (klen_base == 4'hF) ? 4'hF : klen_base + 4'd1;
    assign kflags_val = kflags_reg & {klen_reg == KEY_FAM_LEN, klen_reg == KEY_CONF_LEN,
                                      klen_reg == KEY_DET_LEN};

    // detector value bytes; first byte of a value restarts the name
    assign det_idx  = (vlen_reg == 2'd0) ? '0 : det_count_reg;
    assign det_room = det_idx < DET_CNT_W'(DET_DEPTH);

    // numeric value: one digit per character, decimal or 0x hex
    assign is_num  = kflags_reg[KB_CONF] || kflags_reg[KB_FAM];
    assign x_start = !vxpend_reg && !vhex_reg && (vlen_reg == 2'd1) && (acc_reg == 32'd0)
                     && ((ch == CH_LX) || (ch == CH_UX));
    assign hex_eff = vhex_reg || vxpend_reg;
    assign acc_eff = vxpend_reg ? 32'd0 : acc_reg;

    always_comb begin
        dig_ok  = 1'b1;
        dig_val = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            dig_val = 4'(ch - 8'h30);
        end else if (hex_eff && ch >= 8'h61 && ch <= 8'h66) begin
            dig_val = 4'(ch - 8'h57);
        end else if (hex_eff && ch >= 8'h41 && ch <= 8'h46) begin
            dig_val = 4'(ch - 8'h37);
        end else begin
            dig_ok = 1'b0;
        end
    end

    assign acc_wide = {4'b0, acc_eff};
    assign prod     = hex_eff ? (acc_wide << 4) : ((acc_wide << 3) + (acc_wide << 1));
    assign sum      = prod + {32'b0, dig_val};
    assign ovf      = sum[35:32] != 4'd0;

    // close of a value token
    assign conf_sat = (acc_reg > {25'b0, CONF_MAX}) ? CONF_MAX : acc_reg[6:0];
    assign fin_ok   = !kflags_reg[KB_DET] && !verr_reg && !vxpend_reg && vany_reg;
    assign fin_conf = (fin_ok && kflags_reg[KB_CONF]) ? conf_sat : conf_reg;
    assign fin_fam  = (fin_ok && !kflags_reg[KB_CONF] && kflags_reg[KB_FAM])
                      ? acc_reg[7:0] : fam_reg;

    // line verdict, valid in the cycle the end-of-line word is taken
    assign src_ok  = in_src_reg != SRC_INVALID;
    assign pre_ok  = (phase_reg != PH_LEAD) && (phase_reg != PH_PREFIX)
                     && (phase_reg != PH_FAIL);
    assign line_ok = src_ok && pre_ok;

    always_comb begin
        line_sum.valid = line_ok && have_det_reg && (det_count_reg != '0);
        line_sum.src   = in_src_reg;
        line_sum.conf  = line_ok ? ((phase_reg == PH_VALUE) ? fin_conf : conf_reg) : 7'd0;
        line_sum.fam   = line_ok ? ((phase_reg == PH_VALUE) ? fin_fam : fam_reg) : 8'd0;
        line_sum.cnt   = line_ok ? det_count_reg : '0;
    end

    always_comb begin
        phase_next     = phase_reg;
        pfx_pos_next   = pfx_pos_reg;
        klen_next      = klen_reg;
        kflags_next    = kflags_reg;
        acc_next       = acc_reg;
        vhex_next      = vhex_reg;
        vxpend_next    = vxpend_reg;
        vany_next      = vany_reg;
        verr_next      = verr_reg;
        vlen_next      = vlen_reg;
        det_count_next = det_count_reg;
        conf_next      = conf_reg;
        fam_next       = fam_reg;
        have_det_next  = have_det_reg;
        det_we         = 1'b0;
        if (line_done) begin
            phase_next     = PH_LEAD;
            pfx_pos_next   = '0;
            klen_next      = 4'd0;
            kflags_next    = 3'b111;
            acc_next       = 32'd0;
            vhex_next      = 1'b0;
            vxpend_next    = 1'b0;
            vany_next      = 1'b0;
            verr_next      = 1'b0;
            vlen_next      = 2'd0;
            det_count_next = '0;
            conf_next      = 7'd0;
            fam_next       = 8'd0;
            have_det_next  = 1'b0;
        end else if (step) begin
            unique case (phase_reg)
                PH_LEAD, PH_PREFIX: begin
                    if (!(phase_reg == PH_LEAD && ws)) begin
                        if (!pfx_hit) begin
                            phase_next = PH_FAIL;
                        end else begin
                            pfx_pos_next = pfx_pos_inc[PFX_POS_W-1:0];
                            phase_next   = (pfx_pos_inc >= (PFX_POS_W+1)'(PREFIX_LENGTH))
                                           ? PH_AFTER : PH_PREFIX;
                        end
                    end
                end
                PH_AFTER: begin
                    if (ch_nul)  phase_next = PH_ENDED;
                    else if (ws) phase_next = PH_GAP;
                    else         phase_next = PH_FAIL;
                end
                PH_GAP: begin
                    if (ch_nul) begin
                        phase_next = PH_ENDED;
                    end else if (ch == CH_EQ) begin
                        phase_next = PH_SKIP;
                    end else if (!ws) begin
                        klen_next   = klen_inc;
                        kflags_next = kflags_key;
                        phase_next  = PH_KEY;
                    end
                end
                PH_KEY: begin
                    if (ch_nul) begin
                        phase_next = PH_ENDED;
                    end else if (ws) begin
                        phase_next = PH_GAP;
                    end else if (ch == CH_EQ) begin
                        kflags_next = kflags_val;
                        acc_next    = 32'd0;
                        vhex_next   = 1'b0;
                        vxpend_next = 1'b0;
                        vany_next   = 1'b0;
                        verr_next   = 1'b0;
                        vlen_next   = 2'd0;
                        phase_next  = PH_VALUE;
                    end else begin
                        klen_next   = klen_inc;
                        kflags_next = kflags_key;
                    end
                end
                PH_VALUE: begin
                    if (ch_nul || ws) begin
                        conf_next  = fin_conf;
                        fam_next   = fin_fam;
                        phase_next = ch_nul ? PH_ENDED : PH_GAP;
                    end else begin
                        vlen_next = (vlen_reg == 2'd3) ? 2'd3 : vlen_reg + 2'd1;
                        if (kflags_reg[KB_DET]) begin
                            if (vlen_reg == 2'd0) have_det_next = 1'b1;
                            det_count_next = det_idx;
                            if (det_room) begin
                                det_we         = 1'b1;
                                det_count_next = det_idx + 1'b1;
                            end
                        end else if (is_num && !verr_reg) begin
                            if (x_start) begin
                                vxpend_next = 1'b1;
                            end else begin
                                if (vxpend_reg) begin
                                    vhex_next   = 1'b1;
                                    vxpend_next = 1'b0;
                                    acc_next    = 32'd0;
                                end
                                if (!dig_ok || ovf) begin
                                    verr_next = 1'b1;
                                end else begin
                                    acc_next  = sum[31:0];
                                    vany_next = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_SKIP: begin
                    if (ch_nul)  phase_next = PH_ENDED;
                    else if (ws) phase_next = PH_GAP;
                end
                PH_FAIL, PH_ENDED: begin
                    phase_next = phase_reg;
                end
                default: begin
                    phase_next = PH_FAIL;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_LEAD;
            pfx_pos_reg   <= '0;
            klen_reg      <= 4'd0;
            kflags_reg    <= 3'b111;
            acc_reg       <= 32'd0;
            vhex_reg      <= 1'b0;
            vxpend_reg    <= 1'b0;
            vany_reg      <= 1'b0;
            verr_reg      <= 1'b0;
            vlen_reg      <= 2'd0;
            det_count_reg <= '0;
            conf_reg      <= 7'd0;
            fam_reg       <= 8'd0;
            have_det_reg  <= 1'b0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            phase_reg     <= phase_next;
            pfx_pos_reg   <= pfx_pos_next;
            klen_reg      <= klen_next;
            kflags_reg    <= kflags_next;
            acc_reg       <= acc_next;
            vhex_reg      <= vhex_next;
            vxpend_reg    <= vxpend_next;
            vany_reg      <= vany_next;
            verr_reg      <= verr_next;
            vlen_reg      <= vlen_next;
            det_count_reg <= det_count_next;
            conf_reg      <= conf_next;
            fam_reg       <= fam_next;
            have_det_reg  <= have_det_next;
        end
    end

    // payload and name store, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_eol_reg  <= s_tlast;
            in_src_reg  <= s_tuser;
        end
        if (det_we) det_store_reg[det_idx] <= ch;
    end

    assign rd_byte = det_store_reg[rd_idx];

endmodule

`default_nettype wire

>>> hw/rtl/alkv_emit.sv
// Result sequencer: turns a line verdict into a run of result words and holds
// the output register. Depends on alkv_pkg; reads the name store in alkv_parse.
`default_nettype none

module alkv_emit
    import alkv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 line_done,
    input  line_sum_t            line_sum,
    output logic                 emit_busy,
    output logic [DET_CNT_W-1:0] rd_idx,
    input  logic [7:0]           rd_byte,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    output logic [TUSER_W-1:0]   m_tuser
);

    logic                 busy_reg, busy_next;
    logic [DET_CNT_W-1:0] idx_reg, idx_next;
    line_sum_t            sum_reg;

    logic                 out_valid_reg;
    logic                 res_valid_reg;
    logic [TUSER_W-1:0]   res_src_reg;
    logic [6:0]           res_conf_reg;
    logic [7:0]           res_fam_reg;
    logic [4:0]           res_len_reg;
    logic [7:0]           res_byte_reg;
    logic [4:0]           res_index_reg;
    logic                 res_last_reg;

    line_sum_t            cur_sum;
    logic [DET_CNT_W-1:0] cur_idx;
    logic                 has_bytes, is_last, out_free, load;

    assign cur_sum   = busy_reg ? sum_reg : line_sum;
    assign cur_idx   = busy_reg ? idx_reg : '0;
    assign has_bytes = cur_sum.cnt != '0;
    assign is_last   = !has_bytes || (cur_idx == cur_sum.cnt - 1'b1);
    assign out_free  = !out_valid_reg || m_tready;
    assign load      = out_free && (busy_reg || line_done);
    assign rd_idx    = cur_idx;
    assign emit_busy = busy_reg;

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (line_done) begin
            busy_next = !(load && is_last);
            idx_next  = load ? DET_CNT_W'(1) : '0;
        end else if (busy_reg && load) begin
            busy_next = !is_last;
            idx_next  = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            if (load)          out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (line_done) sum_reg <= line_sum;
        if (load) begin
            res_valid_reg <= cur_sum.valid;
            res_src_reg   <= cur_sum.src;
            res_conf_reg  <= cur_sum.conf;
            res_fam_reg   <= cur_sum.fam;
            res_len_reg   <= 5'(cur_sum.cnt);
            res_byte_reg  <= has_bytes ? rd_byte : 8'd0;
            res_index_reg <= has_bytes ? 5'(cur_idx) : 5'd0;
            res_last_reg  <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = res_last_reg;
    assign m_tuser  = res_src_reg;
    assign m_tdata  = {6'b0, res_index_reg, res_byte_reg, res_len_reg, res_fam_reg,
                       res_conf_reg, res_valid_reg};

endmodule

`default_nettype wire

>>> hw/rtl/alkv_checker.sv
// Port-level checks on the result channel of the alarm line parser, bound to
// the top level. Depends on alkv_pkg and the assertion macro header.
`default_nettype none
`include "alarm_line_key_value_parser_assert.svh"

module alkv_checker
    import alkv_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic [TUSER_W-1:0]   m_tuser
);

    // stalled result word holds
    `ALKV_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result word changed while stalled")

    // a valid verdict always carries a name
    `ALKV_ASSERT_SAME(a_valid_len, m_tvalid && m_tdata[0], m_tdata[20:16] != 5'd0, "valid verdict with empty name")

    // name index stays inside the name
    `ALKV_ASSERT_SAME(a_idx_range, m_tvalid && (m_tdata[20:16] != 5'd0), m_tdata[33:29] < m_tdata[20:16], "name index beyond length")

    // confidence is saturated
    `ALKV_ASSERT_SAME(a_conf_sat, m_tvalid, m_tdata[7:1] <= CONF_MAX, "confidence above limit")

    // a run continues with the next byte right after a taken word
    `ALKV_ASSERT_NEXT(a_run_seq, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[33:29] == $past(m_tdata[33:29]) + 5'd1), "run index did not advance")

endmodule

bind alarm_line_key_value_parser alkv_checker u_alkv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> dv/alarm_line_key_value_parser_tb.sv
// Self-checking testbench for alarm_line_key_value_parser: a table of directed lines,
// then random lines, every result word checked against an in-bench line parser.
// Depends on alkv_pkg and the parser RTL.
`default_nettype none

module alarm_line_key_value_parser_tb;
    import alkv_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 32;   // output register plus margin
    localparam int RANDOM_WORDS     = 250;
    localparam int RANDOM_LINES_MIN = 12;
    localparam int LONG_HOLD_CYCLES = 200;

    // One expected result word, fields as the block reports them
    typedef struct {
        logic       valid;
        logic [1:0] src;
        logic [6:0] conf;
        logic [7:0] fam;
        logic [4:0] len;
        logic [7:0] nbyte;
        logic [4:0] nidx;
        logic       last;
    } verdict_word_t;

    // Directed line: lead text, first pfx_len prefix bytes, tail text.
    // nul_at marks a tail position sent as a zero byte (-1: none).
    // Where typed is set, the line's verdict is also given by hand.
    typedef struct {
        string      lead;
        int         pfx_len;
        string      tail;
        int         nul_at;
        logic [1:0] src;
        bit         typed;
        logic       t_valid;
        int         t_conf;
        int         t_fam;
        int         t_len;
    } line_row_t;

    localparam int NUM_ROWS = 23;

    line_row_t line_table [NUM_ROWS] = '{
        // empty line: nothing matched
        '{"", 0, "", -1, 2'd0, 1, 1'b0, 0, 0, 0},
        // all leading whitespace kinds, small hex fam
        '{" \t\r\n", PREFIX_LENGTH, " detector=d1 conf=55 fam=0x1F", -1, 2'd1,
          1, 1'b1, 55, 31, 2},
        // conf saturates, fam keeps its low byte
        '{"", PREFIX_LENGTH, " detector=abc conf=200 fam=300", -1, 2'd2,
          1, 1'b1, 100, 44, 3},
        // same line from the invalid source
        '{"", PREFIX_LENGTH, " detector=abc conf=200 fam=300", -1, SRC_INVALID,
          1, 1'b0, 0, 0, 0},
        // prefix broken midway
        '{"", 7, "X detector=a", -1, 2'd0, 1, 1'b0, 0, 0, 0},
        // prefix alone
        '{"", PREFIX_LENGTH, "", -1, 2'd0, 1, 1'b0, 0, 0, 0},
        // junk glued to the prefix
        '{"", PREFIX_LENGTH, "x detector=a", -1, 2'd1, 1, 1'b0, 0, 0, 0},
        // bare 0x / 0X rejected; detector value of a single '='
        '{"", PREFIX_LENGTH, " conf=0x fam=0X detector==", -1, 2'd2, 1, 1'b1, 0, 0, 1},
        // 32-bit ceiling accepted, one past it rejected
        '{"", PREFIX_LENGTH, " conf=4294967295 fam=4294967296", -1, 2'd0,
          1, 1'b0, 100, 0, 0},
        '{"", PREFIX_LENGTH, " conf=0xFFFFFFFF fam=0x100000000", -1, 2'd1,
          1, 1'b0, 100, 0, 0},
        // token opening with '=', empty values, trailing junk
        '{"", PREFIX_LENGTH, " =detector=zz detector= conf= fam=12z", -1, 2'd2,
          1, 1'b0, 0, 0, 0},
        // zero byte ends the text inside a value
        '{"", PREFIX_LENGTH, " detector=ab# conf=9", 12, 2'd0, 1, 1'b1, 0, 0, 2},
        // zero byte inside the prefix
        '{"", 4, "#", 0, 2'd1, 1, 1'b0, 0, 0, 0},
        // detector cut to the store depth
        '{"\t", PREFIX_LENGTH, " detector=ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmn", -1,
          2'd2, 1, 1'b1, 0, 0, 31},
        // later detector wins, near-miss keys skipped
        '{"", PREFIX_LENGTH,
          " detector=first detector=xy conf=7 cnf=9 conff=3 fa=1 famm=2 detectorx=q",
          -1, 2'd0, 0, 1'b0, 0, 0, 0},
        // top-bit name bytes
        '{"", PREFIX_LENGTH, " detector=\377\200\001 fam=255", -1, 2'd1, 0, 1'b0, 0, 0, 0},
        // tab, CR and LF as separators
        '{"", PREFIX_LENGTH, "\tconf=100\rfam=0\n detector=q", -1, 2'd2, 1, 1'b1, 100, 0, 1},
        // bare keys skipped
        '{"", PREFIX_LENGTH, " detector conf fam=0x0a", -1, 2'd0, 1, 1'b0, 0, 10, 0},
        // mixed-case hex, leading zeros
        '{"", PREFIX_LENGTH, " conf=0x1aB fam=007", -1, 2'd1, 1, 1'b0, 100, 7, 0},
        // x in the wrong place is junk
        '{"", PREFIX_LENGTH, " conf=00x5 fam=x5 detector=k", -1, 2'd2, 1, 1'b1, 0, 0, 1},
        // zero byte right after the prefix, later text ignored
        '{"", PREFIX_LENGTH, "#zz detector=a", 0, 2'd2, 1, 1'b0, 0, 0, 0},
        // zero byte after leading whitespace
        '{"", 0, "  #", 2, 2'd0, 1, 1'b0, 0, 0, 0},
        // rejected conf keeps the earlier one; '=' inside a name
        '{"", PREFIX_LENGTH, " conf=5 conf=x conf=0x detector=x=y", -1, 2'd1,
          1, 1'b1, 5, 0, 3}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [7:0] char_byte
    logic                 s_tlast;   // end_of_line
    logic [TUSER_W-1:0]   s_tuser;   // [1:0] source
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [0] valid_res, [7:1] confidence, [15:8] families,
                                     // [20:16] detector_length, [28:21] name_byte,
                                     // [33:29] name_index, [39:34] zero
    logic                 m_tlast;   // last
    logic [TUSER_W-1:0]   m_tuser;   // [1:0] source_echo

    alarm_line_key_value_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Scoreboard
    verdict_word_t expected_words [$];
    verdict_word_t line_verdict;     // first word of the latest line
    int            mismatches = 0;
    int            cycle_count = 0;
    int            words_sent = 0;
    bit            long_hold_req = 1'b0;

    // Idle pattern state of the sender
    int send_mode_left = 0;
    bit send_calm = 1'b0;

    // Line parser state
    phase_t     line_phase;
    int         pfx_pos;
    int         key_len;
    logic [2:0] key_cand;            // still-matching keys, bits at KB_*
    logic [31:0] val_acc;
    bit         val_hex, val_xpend, val_any, val_err;
    int         val_len;
    logic [7:0] det_bytes [DET_DEPTH];
    int         det_cnt;
    logic [6:0] conf_saved;
    logic [7:0] fam_saved;
    bit         det_seen;

    //------------------------------------------------------------------
    // Clock, cycle count, watchdog
    //------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("FAILED: results differ");
        $finish;
    end

    //------------------------------------------------------------------
    // Line parser: per-character update, verdict at end of line
    //------------------------------------------------------------------
    function automatic void clear_line_state();
        line_phase = PH_LEAD;
        pfx_pos    = 0;
        key_len    = 0;
        key_cand   = '1;
        val_acc    = '0;
        val_hex    = 1'b0;
        val_xpend  = 1'b0;
        val_any    = 1'b0;
        val_err    = 1'b0;
        val_len    = 0;
        det_cnt    = 0;
        conf_saved = '0;
        fam_saved  = '0;
        det_seen   = 1'b0;
    endfunction

    function automatic void key_letter(logic [7:0] ch);
        if (key_len >= KEY_DET_LEN || KEY_DET_TEXT[key_len] != ch) key_cand[KB_DET] = 1'b0;
        if (key_len >= KEY_CONF_LEN || KEY_CONF_TEXT[key_len] != ch) key_cand[KB_CONF] = 1'b0;
        if (key_len >= KEY_FAM_LEN || KEY_FAM_TEXT[key_len] != ch) key_cand[KB_FAM] = 1'b0;
        if (key_len < 15) key_len++;
    endfunction

    function automatic void open_value();
        if (key_len != KEY_DET_LEN) key_cand[KB_DET] = 1'b0;
        if (key_len != KEY_CONF_LEN) key_cand[KB_CONF] = 1'b0;
        if (key_len != KEY_FAM_LEN) key_cand[KB_FAM] = 1'b0;
        val_acc   = '0;
        val_hex   = 1'b0;
        val_xpend = 1'b0;
        val_any   = 1'b0;
        val_err   = 1'b0;
        val_len   = 0;
    endfunction

    function automatic void value_letter(logic [7:0] ch);
        int          first;
        logic [31:0] base;
        logic [31:0] digit;
        first = val_len;
        if (val_len < 3) val_len++;
        // detector value: raw bytes, a new value restarts the store
        if (key_cand[KB_DET]) begin
            if (first == 0) begin
                det_cnt  = 0;
                det_seen = 1'b1;
            end
            if (det_cnt < DET_DEPTH) begin
                det_bytes[det_cnt] = ch;
                det_cnt++;
            end
            return;
        end
        if (!(key_cand[KB_CONF] || key_cand[KB_FAM]) || val_err) return;
        if (val_xpend) begin
            // first char after 0x: restart as hex
            val_xpend = 1'b0;
            val_any   = 1'b0;
            val_hex   = 1'b1;
            val_acc   = '0;
        end else if (first == 1 && !val_hex && val_acc == 0 && (ch == CH_LX || ch == CH_UX)) begin
            val_xpend = 1'b1;
            return;
        end
        base = val_hex ? 32'd16 : 32'd10;
        if (ch >= 8'h30 && ch <= 8'h39) digit = ch - 8'h30;                   // 0-9
        else if (val_hex && ch >= 8'h61 && ch <= 8'h66) digit = ch - 8'h61 + 10; // a-f
        else if (val_hex && ch >= 8'h41 && ch <= 8'h46) digit = ch - 8'h41 + 10; // A-F
        else begin
            val_err = 1'b1;
            return;
        end
        if (val_acc > (32'hFFFF_FFFF - digit) / base) begin
            val_err = 1'b1;
            return;
        end
        val_acc = val_acc * base + digit;
        val_any = 1'b1;
    endfunction

    function automatic void close_value();
        if (key_cand[KB_DET] || val_err || val_xpend || !val_any) return;
        if (key_cand[KB_CONF]) conf_saved = (val_acc > CONF_MAX) ? CONF_MAX : val_acc[6:0];
        else if (key_cand[KB_FAM]) fam_saved = val_acc[7:0];
    endfunction

    // End of line: one word per stored name byte, or a single word
    function automatic void emit_verdict(logic [1:0] src);
        bit            src_ok, pfx_ok, good;
        int            cnt, n, i;
        verdict_word_t w;
        src_ok = (src != SRC_INVALID);
        pfx_ok = !(line_phase inside {PH_LEAD, PH_PREFIX, PH_FAIL});
        if (line_phase == PH_VALUE) close_value();
        cnt  = (src_ok && pfx_ok) ? det_cnt : 0;
        good = src_ok && pfx_ok && det_seen && cnt > 0;
        n    = (cnt > 0) ? cnt : 1;
        for (i = 0; i < n; i++) begin
            w.valid = good;
            w.src   = src;
            w.conf  = (src_ok && pfx_ok) ? conf_saved : 7'd0;
            w.fam   = (src_ok && pfx_ok) ? fam_saved : 8'd0;
            w.len   = 5'(cnt);
            w.nbyte = (cnt > 0) ? det_bytes[i] : 8'd0;
            w.nidx  = (cnt > 0) ? 5'(i) : 5'd0;
            w.last  = (i == n - 1);
            expected_words.push_back(w);
            if (i == 0) line_verdict = w;
        end
        clear_line_state();
    endfunction

    function automatic void predict_word(logic [7:0] ch, logic eol, logic [1:0] src);
        bit ws;
        if (eol) begin
            emit_verdict(src);
            return;
        end
        ws = (ch == CH_SP) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
        case (line_phase)
            PH_LEAD, PH_PREFIX: begin
                if (line_phase == PH_LEAD) begin
                    if (ws) return;
                    pfx_pos = 0;
                end
                if (ch == CH_NUL || pfx_pos >= 31 || ch != PREFIX_TABLE[pfx_pos]) begin
                    line_phase = PH_FAIL;
                end else begin
                    pfx_pos++;
                    line_phase = (pfx_pos >= PREFIX_LENGTH) ? PH_AFTER : PH_PREFIX;
                end
            end
            PH_AFTER: begin
                if (ch == CH_NUL) line_phase = PH_ENDED;
                else line_phase = ws ? PH_GAP : PH_FAIL;
            end
            PH_GAP: begin
                if (ch == CH_NUL) line_phase = PH_ENDED;
                else if (!ws) begin
                    if (ch == CH_EQ) line_phase = PH_SKIP;
                    else begin
                        key_len  = 0;
                        key_cand = '1;
                        key_letter(ch);
                        line_phase = PH_KEY;
                    end
                end
            end
            PH_KEY: begin
                if (ch == CH_NUL) line_phase = PH_ENDED;
                else if (ws) line_phase = PH_GAP;
                else if (ch == CH_EQ) begin
                    open_value();
                    line_phase = PH_VALUE;
                end else key_letter(ch);
            end
            PH_VALUE: begin
                if (ch == CH_NUL || ws) begin
                    close_value();
                    line_phase = (ch == CH_NUL) ? PH_ENDED : PH_GAP;
                end else value_letter(ch);
            end
            PH_SKIP: begin
                if (ch == CH_NUL) line_phase = PH_ENDED;
                else if (ws) line_phase = PH_GAP;
            end
            default: ;
        endcase
    endfunction

    //------------------------------------------------------------------
    // Checking
    //------------------------------------------------------------------
    function automatic void compare_field(string what, logic [31:0] expv, logic [31:0] actv);
        if (actv !== expv) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, expv, actv);
            mismatches++;
        end
    endfunction

    function automatic void check_word();
        verdict_word_t w;
        if (expected_words.size() == 0) begin
            $display("%0t: result word with nothing expected: tdata=%h last=%b user=%0d",
                     $time, m_tdata, m_tlast, m_tuser);
            mismatches++;
            return;
        end
        w = expected_words.pop_front();
        compare_field("valid_res", w.valid, m_tdata[0]);
        compare_field("source_echo", w.src, m_tuser);
        compare_field("confidence", w.conf, m_tdata[7:1]);
        compare_field("families", w.fam, m_tdata[15:8]);
        compare_field("detector_length", w.len, m_tdata[20:16]);
        compare_field("name_byte", w.nbyte, m_tdata[28:21]);
        compare_field("name_index", w.nidx, m_tdata[33:29]);
        compare_field("tdata padding", 0, m_tdata[39:34]);
        compare_field("last", w.last, m_tlast);
    endfunction

    //------------------------------------------------------------------
    // Idle pattern: stretches with no gaps, else mostly short gaps, few long
    //------------------------------------------------------------------
    function automatic int pick_gap(inout int mode_left, inout bit calm);
        int roll;
        if (mode_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    //------------------------------------------------------------------
    // Line building
    //------------------------------------------------------------------
    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 3))
            0: return CH_SP;
            1: return CH_TAB;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // Any byte that does not end a token
    function automatic logic [7:0] pick_name_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF);
        return b;
    endfunction

    task automatic add_text(ref logic [7:0] q[$], input string s);
        int k;
        for (k = 0; k < s.len(); k++) q.push_back(s[k]);
    endtask

    task automatic add_number(ref logic [7:0] q[$]);
        string s;
        case ($urandom_range(0, 6))
            0: s = $sformatf("%0d", $urandom_range(0, 120));
            1: s = $sformatf("%0d", $urandom());
            2: s = $sformatf("0x%0h", $urandom());
            3: s = $sformatf("0x%0h", $urandom_range(0, 255));
            4: s = $sformatf("%0d%0d", $urandom_range(1, 9), $urandom());   // mostly overflow
            5: s = $sformatf("0x%0h%08h", $urandom_range(1, 15), $urandom()); // overflow
            default: begin
                case ($urandom_range(0, 5))
                    0: s = "0x";
                    1: s = "12a";
                    2: s = "x1";
                    3: s = "0xg";
                    4: s = "-5";
                    default: s = "";
                endcase
            end
        endcase
        if ($urandom_range(0, 1)) s = s.toupper();
        add_text(q, s);
    endtask

    task automatic add_token(ref logic [7:0] q[$]);
        int len;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                add_text(q, "detector=");
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 6);
                repeat (len) q.push_back(pick_name_byte());
            end
            3, 4: begin
                add_text(q, "conf=");
                add_number(q);
            end
            5, 6: begin
                add_text(q, "fam=");
                add_number(q);
            end
            7: begin
                case ($urandom_range(0, 6))
                    0: add_text(q, "detector");
                    1: add_text(q, "conff=1");
                    2: add_text(q, "co=5");
                    3: add_text(q, "detectorr=x");
                    4: add_text(q, "=junk");
                    5: add_text(q, "fam=");
                    default: add_text(q, "detector=");
                endcase
            end
            default: begin
                // random word, '=' inside makes a random key
                repeat ($urandom_range(1, 6)) q.push_back(pick_name_byte());
            end
        endcase
    endtask

    task automatic build_random_line(ref logic [7:0] q[$]);
        int kind, k, cut;
        q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            // well-formed frame with random tokens
            repeat ($urandom_range(0, 2)) q.push_back(pick_ws());
            for (k = 0; k < PREFIX_LENGTH; k++) q.push_back(PREFIX_TABLE[k]);
            repeat ($urandom_range(0, 4)) begin
                repeat ($urandom_range(1, 2)) q.push_back(pick_ws());
                add_token(q);
            end
            if ($urandom_range(0, 9) == 0) begin
                q.push_back(CH_NUL);
                add_text(q, " conf=3 detector=zz");
            end
        end else if (kind < 87) begin
            // cut or bent prefix
            cut = $urandom_range(0, PREFIX_LENGTH);
            for (k = 0; k < cut; k++) q.push_back(PREFIX_TABLE[k]);
            q.push_back(8'($urandom_range(0, 255)));
            add_text(q, " detector=a");
        end else begin
            // raw noise
            repeat ($urandom_range(0, 16)) q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    //------------------------------------------------------------------
    // Driving: one word per handshake, valid held across back-to-back words
    //------------------------------------------------------------------
    task automatic send_word(input logic [7:0] ch, input logic eol, input logic [1:0] src);
        int gap;
        gap = pick_gap(send_mode_left, send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eol;
        s_tuser  <= src;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        predict_word(ch, eol, src);
        words_sent++;
    endtask

    // Characters carry random tuser, the end-of-line word random tdata
    task automatic send_line(ref logic [7:0] q[$], input logic [1:0] src);
        int k;
        for (k = 0; k < q.size(); k++) send_word(q[k], 1'b0, 2'($urandom_range(0, 3)));
        send_word(8'($urandom_range(0, 255)), 1'b1, src);
    endtask

    //------------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off on request
    //------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        int mode_left;
        bit calm;
        stall     = 0;
        mode_left = 0;
        calm      = 1'b0;
        m_tready  = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1) check_word();
            if (long_hold_req) begin
                // block fills up while the sender keeps offering
                long_hold_req = 1'b0;
                stall = LONG_HOLD_CYCLES;
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall = pick_gap(mode_left, calm);
            end
        end
    end

    //------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] line_bytes [$];
        logic [1:0] src;
        int         r, k, rand_start, rand_lines;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        s_tuser  = '0;
        aresetn  = 1'b0;
        foreach (det_bytes[k]) det_bytes[k] = '0;
        clear_line_state();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed lines
        for (r = 0; r < NUM_ROWS; r++) begin
            line_bytes.delete();
            add_text(line_bytes, line_table[r].lead);
            for (k = 0; k < line_table[r].pfx_len; k++) line_bytes.push_back(PREFIX_TABLE[k]);
            for (k = 0; k < line_table[r].tail.len(); k++) begin
                if (k == line_table[r].nul_at) line_bytes.push_back(CH_NUL);
                else line_bytes.push_back(line_table[r].tail[k]);
            end
            send_line(line_bytes, line_table[r].src);
            if (line_table[r].typed) begin
                compare_field($sformatf("line %0d valid_res", r),
                              line_table[r].t_valid, line_verdict.valid);
                compare_field($sformatf("line %0d confidence", r),
                              line_table[r].t_conf, line_verdict.conf);
                compare_field($sformatf("line %0d families", r),
                              line_table[r].t_fam, line_verdict.fam);
                compare_field($sformatf("line %0d detector_length", r),
                              line_table[r].t_len, line_verdict.len);
            end
        end

        // random lines, with one long receiver hold-off at the start
        long_hold_req = 1'b1;
        rand_start = words_sent;
        rand_lines = 0;
        while (words_sent - rand_start < RANDOM_WORDS || rand_lines < RANDOM_LINES_MIN) begin
            build_random_line(line_bytes);
            src = ($urandom_range(0, 7) == 0) ? SRC_INVALID : 2'($urandom_range(0, 2));
            send_line(line_bytes, src);
            rand_lines++;
        end
        s_tvalid <= 1'b0;

        // drain, then leave room for a stray extra word
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> alarm_line_key_value_parser.f
+incdir+hw/rtl
hw/rtl/alkv_pkg.sv
hw/rtl/alkv_parse.sv
hw/rtl/alkv_emit.sv
hw/rtl/alarm_line_key_value_parser.sv
hw/rtl/alkv_checker.sv
dv/alarm_line_key_value_parser_tb.sv
